@@ sv/ppd_pkg.sv @@
// Shared types, constants and a helper function for the point-to-plane projector.
`default_nettype none

package ppd_pkg;

    // Coordinate format and unit-normal scale
    localparam int CW          = 32;
    localparam int UNIT_BITS   = 28;
    localparam int NRM_W       = UNIT_BITS + 1;     // scaled normal magnitude width
    localparam int SUM_W       = 2 * NRM_W + 2;     // sum of three squares
    localparam int ROOT_W      = 30;                // square root width
    localparam int SQ_W        = 62;                // square-root working width
    localparam int SQ_STAGES   = ROOT_W / 2;        // two root bits per stage
    localparam int QUO_W       = 30;                // quotient width
    localparam int DIV_STAGES  = QUO_W / 2;         // two quotient bits per stage
    localparam int DIFF_W      = CW + 1;            // point minus origin
    localparam int DIST_W      = 38;
    localparam int PROJ_W      = 44;

    // Register indexes
    localparam logic CFG_USE_MEASURED    = 1'b0;
    localparam logic CFG_STORED_DISTANCE = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir1_x;
        logic signed [CW-1:0] dir1_y;
        logic signed [CW-1:0] dir1_z;
        logic signed [CW-1:0] dir2_x;
        logic signed [CW-1:0] dir2_y;
        logic signed [CW-1:0] dir2_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] signed_distance;
        logic signed [CW-1:0] proj_x;
        logic signed [CW-1:0] proj_y;
        logic signed [CW-1:0] proj_z;
        logic signed [CW-1:0] mid_x;
        logic signed [CW-1:0] mid_y;
        logic signed [CW-1:0] mid_z;
        logic signed [CW-1:0] shown_distance;
        logic                 degenerate;
    } t_out;

    // Per-item data that rides along the pipeline
    typedef struct packed {
        logic [2:0][CW-1:0]     p;
        logic [2:0][DIFF_W-1:0] d;
        logic [2:0]             neg;
        logic                   degen;
        logic [2:0][NRM_W-1:0]  m;
    } t_side;

    // Clamp to the signed coordinate range
    function automatic logic signed [CW-1:0] sat_cw(input logic signed [71:0] x);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sh7FFFFFFF;
        lo = -hi - 72'sd1;
        if (x > hi) begin
            sat_cw = hi[CW-1:0];
        end else if (x < lo) begin
            sat_cw = lo[CW-1:0];
        end else begin
            sat_cw = x[CW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/ppd_front.sv @@
// Cross product, block scaling of the normal and sum of its squares.
`default_nettype none

module ppd_front import ppd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_in               i_item,
    output logic                   o_valid,
    output logic [SUM_W-1:0]       o_sum,
    output t_side                  o_side
);

    logic               r_v [1:7];
    t_side              r_sd [1:7];
    logic signed [63:0] r_pr [0:5];
    logic [63:0]        r_mag2 [0:2];
    logic [63:0]        r_mag3 [0:2];
    logic [63:0]        r_mag4 [0:2];
    logic [3:0]         r_cnz;
    logic [3:0]         r_cpos [0:3];
    logic [5:0]         r_pos;
    logic [2*NRM_W-1:0] r_sq [0:2];
    logic [SUM_W-1:0]   r_sum;

    t_side              n_sd1;
    t_side              n_sd2;
    t_side              n_sd5;
    logic signed [64:0] n_nrm [0:2];
    logic [63:0]        n_orw;
    logic [3:0]         n_cnz;
    logic [3:0]         n_cpos [0:3];
    logic [5:0]         n_pos;
    logic [63:0]        n_shf [0:2];

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 7; s++) r_v[s] <= r_v[s-1];
        end
    end

    // Stage 1: side data and the six partial products
    always_comb begin
        n_sd1 = '0;
        n_sd1.p[0] = i_item.point_x;
        n_sd1.p[1] = i_item.point_y;
        n_sd1.p[2] = i_item.point_z;
        n_sd1.d[0] = DIFF_W'($signed(i_item.point_x)) - DIFF_W'($signed(i_item.origin_x));
        n_sd1.d[1] = DIFF_W'($signed(i_item.point_y)) - DIFF_W'($signed(i_item.origin_y));
        n_sd1.d[2] = DIFF_W'($signed(i_item.point_z)) - DIFF_W'($signed(i_item.origin_z));
    end

    always_ff @(posedge i_clk) begin
        r_sd[1]  <= n_sd1;
        r_pr[0] <= 64'($signed(i_item.dir1_y)) * 64'($signed(i_item.dir2_z));
        r_pr[1] <= 64'($signed(i_item.dir1_z)) * 64'($signed(i_item.dir2_y));
        r_pr[2] <= 64'($signed(i_item.dir1_z)) * 64'($signed(i_item.dir2_x));
        r_pr[3] <= 64'($signed(i_item.dir1_x)) * 64'($signed(i_item.dir2_z));
        r_pr[4] <= 64'($signed(i_item.dir1_x)) * 64'($signed(i_item.dir2_y));
        r_pr[5] <= 64'($signed(i_item.dir1_y)) * 64'($signed(i_item.dir2_x));
    end

    // Stage 2: normal components, signs and magnitudes
    always_comb begin
        n_sd2 = r_sd[1];
        for (int i = 0; i < 3; i++) begin
            n_nrm[i]     = 65'(r_pr[2*i]) - 65'(r_pr[2*i+1]);
            n_sd2.neg[i] = n_nrm[i][64];
        end
        n_sd2.degen = (n_nrm[0] == '0) && (n_nrm[1] == '0) && (n_nrm[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        r_sd[2] <= n_sd2;
        for (int i = 0; i < 3; i++) begin
            r_mag2[i] <= n_nrm[i][64] ? 64'(-n_nrm[i]) : n_nrm[i][63:0];
        end
    end

    // Stage 3: leading-one search per 16-bit chunk
    always_comb begin
        n_orw = r_mag2[0] | r_mag2[1] | r_mag2[2];
        for (int c = 0; c < 4; c++) begin
            n_cnz[c]  = |n_orw[16*c +: 16];
            n_cpos[c] = '0;
            for (int b = 0; b < 16; b++) begin
                if (n_orw[16*c + b]) n_cpos[c] = 4'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[3] <= r_sd[2];
        r_cnz   <= n_cnz;
        for (int i = 0; i < 3; i++) r_mag3[i] <= r_mag2[i];
        for (int c = 0; c < 4; c++) r_cpos[c] <= n_cpos[c];
    end

    // Stage 4: pick the highest nonzero chunk
    always_comb begin
        n_pos = '0;
        for (int c = 0; c < 4; c++) begin
            if (r_cnz[c]) n_pos = {2'(c), r_cpos[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[4] <= r_sd[3];
        r_pos   <= n_pos;
        for (int i = 0; i < 3; i++) r_mag4[i] <= r_mag3[i];
    end

    // Stage 5: shift so the largest magnitude lands in [2^28, 2^29)
    always_comb begin
        n_sd5 = r_sd[4];
        for (int i = 0; i < 3; i++) begin
            if (r_pos >= 6'(UNIT_BITS)) begin
                n_shf[i] = r_mag4[i] >> (r_pos - 6'(UNIT_BITS));
            end else begin
                n_shf[i] = r_mag4[i] << (6'(UNIT_BITS) - r_pos);
            end
            n_sd5.m[i] = n_shf[i][NRM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[5] <= n_sd5;
    end

    // Stage 6: squares
    always_ff @(posedge i_clk) begin
        r_sd[6] <= r_sd[5];
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= (2*NRM_W)'(r_sd[5].m[i]) * (2*NRM_W)'(r_sd[5].m[i]);
        end
    end

    // Stage 7: sum of squares
    always_ff @(posedge i_clk) begin
        r_sd[7] <= r_sd[6];
        r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    assign o_valid = r_v[7];
    assign o_sum   = r_sum;
    assign o_side  = r_sd[7];

endmodule

`default_nettype wire

@@ sv/ppd_isqrt.sv @@
// Pipelined floor square root, two result bits per stage.
`default_nettype none

module ppd_isqrt import ppd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_sum,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output t_side                  o_side
);

    logic            r_v  [0:SQ_STAGES];
    logic [SQ_W-1:0] r_x  [0:SQ_STAGES];
    logic [SQ_W-1:0] r_r  [0:SQ_STAGES];
    t_side           r_sd [0:SQ_STAGES];

    assign r_v[0]  = i_valid;
    assign r_x[0]  = SQ_W'(i_sum);
    assign r_r[0]  = '0;
    assign r_sd[0] = i_side;

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        localparam int K_HI = ROOT_W - 1 - 2 * s;
        logic [SQ_W-1:0] n_x;
        logic [SQ_W-1:0] n_r;
        logic [SQ_W-1:0] n_b;

        // Try two root bits: subtract when the trial fits
        always_comb begin
            n_x = r_x[s];
            n_r = r_r[s];
            for (int j = 0; j < 2; j++) begin
                n_b = SQ_W'(1) << (2 * (K_HI - j));
                if (n_x >= n_r + n_b) begin
                    n_x = n_x - (n_r + n_b);
                    n_r = (n_r >> 1) + n_b;
                end else begin
                    n_r = n_r >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[s+1]  <= n_x;
            r_r[s+1]  <= n_r;
            r_sd[s+1] <= r_sd[s];
        end
    end

    assign o_valid = r_v[SQ_STAGES];
    assign o_root  = r_r[SQ_STAGES][ROOT_W-1:0];
    assign o_side  = r_sd[SQ_STAGES];

endmodule

`default_nettype wire

@@ sv/ppd_div.sv @@
// Pipelined restoring divider forming the three unit-normal magnitudes.
`default_nettype none

module ppd_div import ppd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [2:0][QUO_W-1:0]  o_quo,
    output t_side                  o_side
);

    localparam int NUM_W = NRM_W + UNIT_BITS + 1;

    logic                  r_v   [0:DIV_STAGES];
    logic [ROOT_W-1:0]     r_len [0:DIV_STAGES];
    logic [2:0][ROOT_W:0]  r_rem [0:DIV_STAGES];
    logic [2:0][QUO_W-1:0] r_lo  [0:DIV_STAGES];
    logic [2:0][QUO_W-1:0] r_q   [0:DIV_STAGES];
    t_side                 r_sd  [0:DIV_STAGES];

    logic [NUM_W-1:0]      n_num [0:2];

    // Rounded numerator: m * 2^28 + len / 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {i_side.m[i], UNIT_BITS'(0)} + NUM_W'(i_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len[0] <= i_root;
        r_sd[0]  <= i_side;
        for (int i = 0; i < 3; i++) begin
            r_rem[0][i] <= (ROOT_W+1)'(n_num[i][NUM_W-1:QUO_W]);
            r_lo[0][i]  <= n_num[i][QUO_W-1:0];
            r_q[0][i]   <= '0;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [2:0][ROOT_W:0]  n_rem;
        logic [2:0][QUO_W-1:0] n_lo;
        logic [2:0][QUO_W-1:0] n_q;
        logic [ROOT_W:0]       n_t;

        // Two quotient bits per lane
        always_comb begin
            n_rem = r_rem[s];
            n_lo  = r_lo[s];
            n_q   = r_q[s];
            n_t   = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 2; j++) begin
                    n_t      = {n_rem[i][ROOT_W-1:0], n_lo[i][QUO_W-1]};
                    n_lo[i]  = n_lo[i] << 1;
                    if (n_t >= (ROOT_W+1)'(r_len[s])) begin
                        n_rem[i] = n_t - (ROOT_W+1)'(r_len[s]);
                        n_q[i]   = {n_q[i][QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem[i] = n_t;
                        n_q[i]   = {n_q[i][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_len[s+1] <= r_len[s];
            r_rem[s+1] <= n_rem;
            r_lo[s+1]  <= n_lo;
            r_q[s+1]   <= n_q;
            r_sd[s+1]  <= r_sd[s];
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_quo   = r_q[DIV_STAGES];
    assign o_side  = r_sd[DIV_STAGES];

endmodule

`default_nettype wire

@@ sv/ppd_back.sv @@
// Distance, projection, midpoint, saturation and the result register.
`default_nettype none

module ppd_back import ppd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [2:0][QUO_W-1:0] i_quo,
    input  wire t_side                 i_side,
    input  wire logic                  i_use_measured,
    input  wire logic signed [CW-1:0]  i_stored_distance,
    output logic                       o_valid,
    output t_out                       o_result
);

    localparam int U_W  = QUO_W + 1;
    localparam int HI_W = DIST_W - 19;

    logic                     r_v [1:5];
    t_side                    r_sd [1:4];
    logic signed [U_W-1:0]    r_u1 [0:2];
    logic signed [U_W-1:0]    r_u2 [0:2];
    logic signed [63:0]       r_ud [0:2];
    logic signed [DIST_W-1:0] r_dist2;
    logic signed [DIST_W-1:0] r_dist3;
    logic signed [DIST_W-1:0] r_dist4;
    logic signed [49:0]       r_ph [0:2];
    logic signed [50:0]       r_pl [0:2];
    logic signed [PROJ_W-1:0] r_proj [0:2];
    t_out                     r_res;

    logic signed [U_W-1:0]    n_u [0:2];
    logic signed [65:0]       n_acc;
    logic signed [HI_W-1:0]   n_hi;
    logic signed [19:0]       n_lo;
    logic signed [71:0]       n_t [0:2];
    logic signed [PROJ_W:0]   n_ms [0:2];
    logic signed [CW-1:0]     n_dsat;
    t_out                     n_res;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 5; s++) r_v[s] <= r_v[s-1];
        end
    end

    // Stage 1: signed unit normal times point-minus-origin
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = i_side.neg[i] ? -$signed({1'b0, i_quo[i]}) : $signed({1'b0, i_quo[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[1] <= i_side;
        for (int i = 0; i < 3; i++) begin
            r_u1[i] <= n_u[i];
            r_ud[i] <= 64'(n_u[i]) * 64'($signed(i_side.d[i]));
        end
    end

    // Stage 2: round the dot product to the distance
    always_comb begin
        n_acc = 66'(r_ud[0]) + 66'(r_ud[1]) + 66'(r_ud[2])
              + (66'sd1 <<< (UNIT_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        r_sd[2] <= r_sd[1];
        r_dist2 <= DIST_W'(n_acc >>> UNIT_BITS);
        for (int i = 0; i < 3; i++) r_u2[i] <= r_u1[i];
    end

    // Stage 3: distance times unit normal as two partial products
    always_comb begin
        n_hi = r_dist2[DIST_W-1:19];
        n_lo = $signed({1'b0, r_dist2[18:0]});
    end

    always_ff @(posedge i_clk) begin
        r_sd[3] <= r_sd[2];
        r_dist3 <= r_dist2;
        for (int i = 0; i < 3; i++) begin
            r_ph[i] <= 50'(n_hi) * 50'(r_u2[i]);
            r_pl[i] <= 51'(n_lo) * 51'(r_u2[i]);
        end
    end

    // Stage 4: combine, round and subtract from the point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = ((72'(r_ph[i]) <<< 19) + 72'(r_pl[i])
                     + (72'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[4] <= r_sd[3];
        r_dist4 <= r_dist3;
        for (int i = 0; i < 3; i++) begin
            r_proj[i] <= PROJ_W'(72'($signed(r_sd[3].p[i])) - n_t[i]);
        end
    end

    // Stage 5: midpoint, clamp, degenerate zeroing and shown distance
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ms[i] = ((PROJ_W+1)'(r_proj[i]) + (PROJ_W+1)'($signed(r_sd[4].p[i]))) >>> 1;
        end
        n_dsat = sat_cw(72'(r_dist4));
        n_res  = '0;
        if (!r_sd[4].degen) begin
            n_res.signed_distance = n_dsat;
            n_res.proj_x          = sat_cw(72'(r_proj[0]));
            n_res.proj_y          = sat_cw(72'(r_proj[1]));
            n_res.proj_z          = sat_cw(72'(r_proj[2]));
            n_res.mid_x           = sat_cw(72'(n_ms[0]));
            n_res.mid_y           = sat_cw(72'(n_ms[1]));
            n_res.mid_z           = sat_cw(72'(n_ms[2]));
        end
        n_res.degenerate     = r_sd[4].degen;
        n_res.shown_distance = i_use_measured ? n_res.signed_distance : i_stored_distance;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_v[5];
    assign o_result = r_res;

endmodule

`default_nettype wire

@@ sv/point_plane_distance_projector.sv @@
// Top level of the point-to-plane distance and projection pipeline.
`default_nettype none

// Takes one item per clock: i_start may be high in every cycle and o_busy
// stays low. Each item passes through 7 front stages for the cross product
// and scaling, 15 square-root stages, 16 divider stages and 5 back stages,
// with o_done high for exactly one cycle when it leaves; the receiver cannot
// stall, so it must take each result in that cycle. Results leave in input
// order. Write the configuration registers only while no item is in flight.
module point_plane_distance_projector import ppd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_in               i_item,
    output logic                   o_done,
    output t_out                   o_result,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CW-1:0]     i_cfg_data
);

    logic                  r_use_measured;
    logic signed [CW-1:0]  r_stored_distance;

    logic                  w_f_valid;
    logic [SUM_W-1:0]      w_f_sum;
    t_side                 w_f_side;
    logic                  w_s_valid;
    logic [ROOT_W-1:0]     w_s_root;
    t_side                 w_s_side;
    logic                  w_d_valid;
    logic [2:0][QUO_W-1:0] w_d_quo;
    t_side                 w_d_side;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_measured    <= 1'b0;
            r_stored_distance <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_USE_MEASURED:    r_use_measured    <= i_cfg_data[0];
                CFG_STORED_DISTANCE: r_stored_distance <= i_cfg_data;
                default:             r_use_measured    <= r_use_measured;
            endcase
        end
    end

    assign o_busy = 1'b0;

    ppd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_item  (i_item),
        .o_valid (w_f_valid),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    ppd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_sum   (w_f_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    ppd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .i_root  (w_s_root),
        .i_side  (w_s_side),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    ppd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_d_valid),
        .i_quo             (w_d_quo),
        .i_side            (w_d_side),
        .i_use_measured    (r_use_measured),
        .i_stored_distance (r_stored_distance),
        .o_valid           (o_done),
        .o_result          (o_result)
    );

endmodule

`default_nettype wire
